FILE: rtl/rat_pkg.sv
package rat_pkg;

  localparam int          MaxTasksDef = 16;
  localparam logic [15:0] GapReset    = 16'd120;
  localparam logic [16:0] DayMinutes  = 17'd1440;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_APPEND  = 3'd1;
  localparam logic [2:0] REQ_ENABLE  = 3'd2;
  localparam logic [2:0] REQ_DISABLE = 3'd3;
  localparam logic [2:0] REQ_FIRE    = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SCHED,
    S_EMIT,
    S_NEXT
  } state_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic        mode;
    logic        rep;
    logic [10:0] mark;
    logic [15:0] period;
    logic [31:0] last;
    logic [31:0] due;
    logic [31:0] count;
  } rec_t;

  typedef struct packed {
    logic        is_fire;
    logic [3:0]  idx;
    logic [3:0]  kind;
    logic [31:0] cnt;
    logic [1:0]  status;
    logic        last_item;
  } res_t;

endpackage

FILE: rtl/reminder_alarm_table.sv
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_ready   | request fields
// out_    | output    | out_valid / out_ready | result fields
// cfg_    | input     | cfg_wr_en             | cfg_wr_data (retrigger gap)
// A request is taken in idle; in_ready stays low until its last beat is loaded
// into the output register.
// Per alarm visited: read, evaluate, next; a firing alarm adds reschedule and emit
// as well, over the single table port and the shared reschedule adder.
// A tick walks every alarm in turn; a non-tick request goes straight to emit, or through
// read, evaluate, reschedule and emit. Output stalls hold the sequencer in emit.
// rst_n is synchronous; the table contents need no clearing.
module reminder_alarm_table #(
  parameter int MAX_TASKS = rat_pkg::MaxTasksDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_now_seconds,
  input  logic [10:0] in_now_minute_of_day,
  input  logic [3:0]  in_task_index,
  input  logic [3:0]  in_task_kind,
  input  logic        in_trigger_mode,
  input  logic        in_repeat_daily,
  input  logic [4:0]  in_alarm_hour,
  input  logic [5:0]  in_alarm_minute,
  input  logic [15:0] in_interval_min,
  input  logic        in_start_enabled,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_fire,
  output logic [3:0]  out_alarm_index,
  output logic [3:0]  out_alarm_kind,
  output logic [31:0] out_alarm_fire_count,
  output logic [31:0] out_total_fires,
  output logic [1:0]  out_status,
  output logic        out_last_item,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int AW    = (IDX_W > 4) ? IDX_W : 4;

  rat_pkg::state_t state_r, state_nxt;
  rat_pkg::rec_t   mem [MAX_TASKS];
  rat_pkg::rec_t   rec_r;
  rat_pkg::rec_t   wr_rec;
  rat_pkg::res_t   pend_r, pend_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [2:0]       op_r, op_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [10:0]      cur_r, cur_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [31:0]      fire_total_r, fire_total_nxt;
  logic [31:0]      kind_cnt_r [4];
  logic             kind_inc;
  logic [MAX_TASKS-1:0] en_r, en_nxt;
  logic             do_fire_r, do_fire_nxt;
  logic [15:0]      gap_r;
  logic             out_valid_r;
  rat_pkg::res_t    out_res_r;
  logic [31:0]      out_total_r;
  logic             load_out;

  logic [CMP_W-1:0] tidx_ext;
  logic [CMP_W-1:0] total_ext;
  logic [AW-1:0]    ptr_ext;
  logic [IDX_W-1:0] tidx_addr;
  logic [10:0]      mark_in;
  logic [11:0]      mark_hi;
  logic             time_due;
  logic             due_now;
  logic [31:0]      cnt_new;
  logic [31:0]      last_new;
  logic [31:0]      mins;
  logic [31:0]      mins_x60;
  logic [31:0]      base;
  logic [31:0]      due_new;
  logic             sched_off;
  logic [CNT_W-1:0] ptr_plus;

  assign tidx_ext  = CMP_W'(in_task_index);
  assign total_ext = CMP_W'(total_r);
  assign tidx_addr = tidx_ext[IDX_W-1:0];
  assign ptr_ext   = AW'(ptr_r);
  assign ptr_plus  = CNT_W'(ptr_r) + CNT_W'(1);
  assign mark_in   = 11'(({6'd0, in_alarm_hour} << 6) - ({6'd0, in_alarm_hour} << 2)
                     + {5'd0, in_alarm_minute});
  assign mark_hi   = {1'b0, rec_r.mark} + 12'd1;
  assign time_due  = (cur_r >= rec_r.mark) && ({1'b0, cur_r} <= mark_hi)
                     && ((rec_r.count == 32'd0) || ((now_r - rec_r.last) > {16'd0, gap_r}));
  assign due_now   = rec_r.mode ? (now_r >= rec_r.due) : time_due;

  // reschedule datapath
  assign cnt_new  = do_fire_r ? rec_r.count + 32'd1 : rec_r.count;
  assign last_new = do_fire_r ? now_r : rec_r.last;
  always_comb begin
    sched_off = 1'b0;
    base      = now_r;
    mins      = 32'd0;
    if (rec_r.mode) begin
      base = last_new;
      mins = {16'd0, rec_r.period};
      if (cnt_new == 32'd0) begin
        base = now_r;
        mins = 32'd0;
      end
    end else if (cur_r < rec_r.mark) begin
      mins = {21'd0, rec_r.mark} - {21'd0, cur_r};
    end else if (rec_r.rep) begin
      mins = 32'(rat_pkg::DayMinutes) - {21'd0, cur_r} + {21'd0, rec_r.mark};
    end else begin
      sched_off = 1'b1;
    end
  end
  assign mins_x60 = (mins << 6) - (mins << 2);
  assign due_new  = sched_off ? 32'd0 : base + mins_x60;

  assign load_out = (state_r == rat_pkg::S_EMIT) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rat_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = rat_pkg::S_EMIT;
          case (in_req_type)
            rat_pkg::REQ_TICK: begin
              if (total_r != '0) state_nxt = rat_pkg::S_READ;
            end
            rat_pkg::REQ_APPEND: begin
              if (total_r != CNT_W'(MAX_TASKS) && in_start_enabled)
                state_nxt = rat_pkg::S_READ;
            end
            rat_pkg::REQ_ENABLE: begin
              if (tidx_ext < total_ext) state_nxt = rat_pkg::S_READ;
            end
            rat_pkg::REQ_FIRE: begin
              if (tidx_ext < total_ext && en_r[tidx_addr]) state_nxt = rat_pkg::S_READ;
            end
            default: state_nxt = rat_pkg::S_EMIT;
          endcase
        end
      end
      rat_pkg::S_READ: state_nxt = rat_pkg::S_EVAL;
      rat_pkg::S_EVAL: begin
        if (op_r == rat_pkg::REQ_TICK && !(en_r[ptr_r] && due_now))
          state_nxt = rat_pkg::S_NEXT;
        else
          state_nxt = rat_pkg::S_SCHED;
      end
      rat_pkg::S_SCHED: state_nxt = rat_pkg::S_EMIT;
      rat_pkg::S_EMIT: begin
        if (load_out) state_nxt = pend_r.last_item ? rat_pkg::S_IDLE : rat_pkg::S_NEXT;
      end
      rat_pkg::S_NEXT: state_nxt = (ptr_plus < total_r) ? rat_pkg::S_READ : rat_pkg::S_EMIT;
      default: state_nxt = rat_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    op_nxt         = op_r;
    now_nxt        = now_r;
    cur_nxt        = cur_r;
    ptr_nxt        = ptr_r;
    total_nxt      = total_r;
    fire_total_nxt = fire_total_r;
    en_nxt         = en_r;
    do_fire_nxt    = do_fire_r;
    pend_nxt       = pend_r;
    kind_inc       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = ptr_r;
    wr_rec         = rec_r;
    case (state_r)
      rat_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_req_type;
          now_nxt  = in_now_seconds;
          cur_nxt  = in_now_minute_of_day;
          pend_nxt = '{is_fire: 1'b0, idx: 4'd0, kind: 4'd0, cnt: 32'd0,
                       status: rat_pkg::ST_OK, last_item: 1'b1};
          case (in_req_type)
            rat_pkg::REQ_TICK: begin
              ptr_nxt = '0;
            end
            rat_pkg::REQ_APPEND: begin
              if (total_r == CNT_W'(MAX_TASKS)) begin
                pend_nxt.status = rat_pkg::ST_FULL;
              end else begin
                ptr_nxt         = total_r[IDX_W-1:0];
                wr_en           = 1'b1;
                wr_addr         = total_r[IDX_W-1:0];
                wr_rec          = '{kind: in_task_kind, mode: in_trigger_mode,
                                    rep: in_repeat_daily, mark: mark_in,
                                    period: in_interval_min, last: 32'd0,
                                    due: 32'd0, count: 32'd0};
                en_nxt[total_r[IDX_W-1:0]] = in_start_enabled;
                total_nxt       = total_r + CNT_W'(1);
                pend_nxt.idx    = 4'(AW'(total_r[IDX_W-1:0]));
                do_fire_nxt     = 1'b0;
              end
            end
            rat_pkg::REQ_ENABLE, rat_pkg::REQ_DISABLE, rat_pkg::REQ_FIRE: begin
              pend_nxt.idx = in_task_index;
              ptr_nxt      = tidx_addr;
              if (!(tidx_ext < total_ext)) begin
                pend_nxt.status = rat_pkg::ST_BAD;
              end else if (in_req_type == rat_pkg::REQ_ENABLE) begin
                en_nxt[tidx_addr] = 1'b1;
                do_fire_nxt       = 1'b0;
              end else if (in_req_type == rat_pkg::REQ_DISABLE) begin
                en_nxt[tidx_addr] = 1'b0;
              end else if (!en_r[tidx_addr]) begin
                pend_nxt.status = rat_pkg::ST_BAD;
              end else begin
                do_fire_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      rat_pkg::S_EVAL: begin
        if (op_r == rat_pkg::REQ_TICK) do_fire_nxt = en_r[ptr_r] && due_now;
      end
      rat_pkg::S_SCHED: begin
        wr_en        = 1'b1;
        wr_rec.count = cnt_new;
        wr_rec.last  = last_new;
        wr_rec.due   = due_new;
        if (sched_off) en_nxt[ptr_r] = 1'b0;
        if (do_fire_r) begin
          fire_total_nxt = fire_total_r + 32'd1;
          kind_inc       = (rec_r.kind < 4'd4);
          pend_nxt = '{is_fire: 1'b1, idx: ptr_ext[3:0], kind: rec_r.kind, cnt: cnt_new,
                       status: rat_pkg::ST_OK, last_item: (op_r != rat_pkg::REQ_TICK)};
        end
      end
      rat_pkg::S_NEXT: begin
        if (ptr_plus < total_r) ptr_nxt = ptr_plus[IDX_W-1:0];
        else pend_nxt = '{is_fire: 1'b0, idx: 4'd0, kind: 4'd0, cnt: 32'd0,
                          status: rat_pkg::ST_OK, last_item: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_rec;
    if (state_r == rat_pkg::S_READ) rec_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rat_pkg::S_IDLE;
      total_r      <= '0;
      fire_total_r <= '0;
      en_r         <= '0;
      gap_r        <= rat_pkg::GapReset;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 4; k++) kind_cnt_r[k] <= '0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      fire_total_r <= fire_total_nxt;
      en_r         <= en_nxt;
      if (cfg_wr_en) gap_r <= cfg_wr_data;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (kind_inc) kind_cnt_r[rec_r.kind[1:0]] <= kind_cnt_r[rec_r.kind[1:0]] + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    now_r     <= now_nxt;
    cur_r     <= cur_nxt;
    ptr_r     <= ptr_nxt;
    do_fire_r <= do_fire_nxt;
    pend_r    <= pend_nxt;
    if (load_out) begin
      out_res_r   <= pend_r;
      out_total_r <= fire_total_r;
    end
  end

  assign in_ready             = (state_r == rat_pkg::S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_is_fire          = out_res_r.is_fire;
  assign out_alarm_index      = out_res_r.idx;
  assign out_alarm_kind       = out_res_r.kind;
  assign out_alarm_fire_count = out_res_r.cnt;
  assign out_total_fires      = out_total_r;
  assign out_status           = out_res_r.status;
  assign out_last_item        = out_res_r.last_item;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(MAX_TASKS)) else $error("alarm count overflow");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("request taken while busy");

  a_fire_counts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rat_pkg::S_SCHED && do_fire_r |=> fire_total_r == $past(fire_total_r) + 32'd1)
    else $error("fire total not bumped");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rat_pkg::S_READ |-> CNT_W'(ptr_r) < total_r) else $error("scan past table");

endmodule
